FILE: rtl/pid_aw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pid_aw_pkg;

  // Configuration register map.
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PROP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX    = 3'd5;

  // Operation of the shared adder.
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

endpackage

`default_nettype wire

FILE: rtl/pid_aw_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module pid_aw_alu import pid_aw_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  wire logic [WIDTH-1:0] a,
  input  wire logic [WIDTH-1:0] b,
  input  wire alu_op_t          op,
  output logic      [WIDTH-1:0] result
);

  logic [WIDTH-1:0] b_eff;
  logic             carry_in;

  // Subtraction is done as addition of the inverted operand plus one.
  always_comb begin
    case (op)
      ALU_SUB: begin
        b_eff    = ~b;
        carry_in = 1'b1;
      end
      default: begin
        b_eff    = b;
        carry_in = 1'b0;
      end
    endcase
  end

  assign result = a + b_eff + WIDTH'(carry_in);

endmodule

`default_nettype wire

FILE: rtl/pid_aw_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module pid_aw_cfg import pid_aw_pkg::*; #(
  parameter int DATA_WIDTH     = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [DATA_WIDTH-1:0]        cfg_data,
  output logic signed [DATA_WIDTH-1:0]      prop,
  output logic signed [DATA_WIDTH-1:0]      integ,
  output logic signed [DATA_WIDTH-1:0]      deriv,
  output logic signed [DATA_WIDTH-1:0]      target,
  output logic signed [DATA_WIDTH-1:0]      dmin,
  output logic signed [DATA_WIDTH-1:0]      dmax
);

  localparam logic [DATA_WIDTH-1:0] UNITY_GAIN = DATA_WIDTH'(1) << GAIN_FRAC_BITS;
  localparam logic [DATA_WIDTH-1:0] MOST_NEG   = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] MOST_POS   = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      prop   <= UNITY_GAIN;
      integ  <= '0;
      deriv  <= '0;
      target <= '0;
      dmin   <= MOST_NEG;
      dmax   <= MOST_POS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROP:   prop   <= cfg_data;
        REG_INTEG:  integ  <= cfg_data;
        REG_DERIV:  deriv  <= cfg_data;
        REG_TARGET: target <= cfg_data;
        REG_MIN:    dmin   <= cfg_data;
        REG_MAX:    dmax   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pid_controller_antiwindup.sv
// Positional PID controller with a clamped integral sum.
//
// Configuration: a write port (cfg_we, cfg_index, cfg_data) sets the six
// registers; writes take effect at once; the user makes them only while the
// block is idle, which the block itself does not enforce. Input transactions
// carry a sample and a clear bit; each yields exactly one drive and clamp flag.
//
// Timing: the error, sum, difference, range, division and products all run
// through one shared adder under a sequencer. Three shift-and-add products
// of DATA_WIDTH steps each dominate a transaction. After a write to the
// integral gain or to either drive limit, the next transaction without clear
// first recomputes the sum bound by restoring division if the gain is non-zero.
// A transaction with clear set skips the arithmetic and goes straight from
// idle to the final state.
//
// in_ready is high only while the sequencer is idle. A finished result waits
// in the output register; a new transaction may be accepted meanwhile, but it
// does not complete until the waiting result has been taken.
// Reset (rst, synchronous) restores the register defaults, empties the error
// history and the sum, and drops out_valid.
`timescale 1ns / 1ps
`default_nettype none

module pid_controller_antiwindup import pid_aw_pkg::*; #(
  parameter int DATA_WIDTH     = 16,
  parameter int GAIN_FRAC_BITS = 8,
  parameter int ACC_WIDTH      = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [DATA_WIDTH-1:0]        cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [DATA_WIDTH-1:0] sample,
  input  wire logic                         clear,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0]      drive,
  output logic                              clamped
);

  localparam int DW        = DATA_WIDTH;
  localparam int GFB       = GAIN_FRAC_BITS;
  localparam int AW        = ACC_WIDTH;
  localparam int ERR_W     = DW + 1;
  localparam int DIFF_W    = DW + 2;
  localparam int NUM_W     = DW + GFB;
  localparam int REM_W     = DW + 1;
  localparam int PROD_NEED = (((DW + AW) > (2 * DW + 2)) ? (DW + AW) : (2 * DW + 2)) + 2;
  localparam int TOT_W     = (PROD_NEED > 64) ? 64 : PROD_NEED;
  localparam int CMP_W     = ((AW > NUM_W) ? AW : NUM_W) + 1;
  localparam int CNT_W     = $clog2(NUM_W + 1);

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(DW - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W - 1);

  localparam logic signed [TOT_W-1:0] SUM_HI = TOT_W'({1'b0, {(AW-1){1'b1}}});
  localparam logic signed [TOT_W-1:0] SUM_LO = ~SUM_HI;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_RANGE = 11'b000_0000_0010,
    S_DIV   = 11'b000_0000_0100,
    S_ERR   = 11'b000_0000_1000,
    S_SUM   = 11'b000_0001_0000,
    S_BND   = 11'b000_0010_0000,
    S_DIFF  = 11'b000_0100_0000,
    S_MUL_P = 11'b000_1000_0000,
    S_MUL_I = 11'b001_0000_0000,
    S_MUL_D = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  // Configuration registers.
  logic signed [DW-1:0] prop;
  logic signed [DW-1:0] integ;
  logic signed [DW-1:0] deriv;
  logic signed [DW-1:0] target;
  logic signed [DW-1:0] dmin;
  logic signed [DW-1:0] dmax;

  pid_aw_cfg #(
    .DATA_WIDTH     (DW),
    .GAIN_FRAC_BITS (GFB)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .prop      (prop),
    .integ     (integ),
    .deriv     (deriv),
    .target    (target),
    .dmin      (dmin),
    .dmax      (dmax)
  );

  state_t state;

  // Controller state and working registers.
  logic signed [ERR_W-1:0]  last_error;
  logic signed [AW-1:0]     error_sum;
  logic                     bound_stale;
  logic signed [DW-1:0]     sample_r;
  logic                     clear_r;
  logic signed [ERR_W-1:0]  err;
  logic signed [AW-1:0]     sum_r;
  logic signed [DIFF_W-1:0] diff;
  logic [NUM_W-1:0]         quo;
  logic [REM_W-1:0]         rem;
  logic [CNT_W-1:0]         cnt;
  logic [TOT_W-1:0]         acc;
  logic [TOT_W-1:0]         mcand;
  logic [DW-1:0]            mplier;

  // Shared adder.
  logic [TOT_W-1:0]         alu_a;
  logic [TOT_W-1:0]         alu_b;
  alu_op_t                  alu_op;
  logic [TOT_W-1:0]         alu_res;
  logic signed [TOT_W-1:0]  alu_s;

  pid_aw_alu #(
    .WIDTH (TOT_W)
  ) u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .op     (alu_op),
    .result (alu_res)
  );

  assign alu_s = alu_res;

  logic [REM_W:0]           trial;
  logic [DW-1:0]            integ_mag;
  logic [REM_W-1:0]         divisor;
  logic signed [DW:0]       range;
  logic [DW:0]              range_mag;
  logic [NUM_W-1:0]         num_init;
  logic                     div_ge;
  logic signed [AW-1:0]     sum_sat;
  logic signed [CMP_W-1:0]  sum_x;
  logic signed [CMP_W-1:0]  bnd_x;
  logic signed [CMP_W-1:0]  neg_bnd;
  logic signed [CMP_W-1:0]  err_sum_x;
  logic signed [TOT_W-1:0]  acc_s;
  logic signed [TOT_W-1:0]  drv_full;
  logic signed [TOT_W-1:0]  max_x;
  logic signed [TOT_W-1:0]  min_x;
  logic                     out_free;
  logic                     mul_last;

  assign trial     = {rem, quo[NUM_W-1]};
  assign integ_mag = integ[DW-1] ? (~integ + 1'b1) : integ;
  assign divisor   = {integ_mag, 1'b0};
  assign range     = alu_res[DW:0];
  assign range_mag = range[DW] ? (~range + 1'b1) : range;
  assign num_init  = NUM_W'(range_mag[DW-1:0]) << GFB;
  assign div_ge    = ~alu_res[TOT_W-1];
  assign mul_last  = (cnt == MUL_LAST);

  assign sum_sat = (alu_s > SUM_HI) ? SUM_HI[AW-1:0] :
                   (alu_s < SUM_LO) ? SUM_LO[AW-1:0] : alu_s[AW-1:0];

  assign sum_x     = CMP_W'(sum_r);
  assign bnd_x     = CMP_W'(quo);
  assign neg_bnd   = -bnd_x;
  assign err_sum_x = CMP_W'(error_sum);

  assign acc_s    = acc;
  assign drv_full = acc_s >>> GFB;
  assign max_x    = TOT_W'(dmax);
  assign min_x    = TOT_W'(dmin);
  assign out_free = ~out_valid | out_ready;

  assign in_ready = (state == S_IDLE);

  // Operand selection for the shared adder.
  always_comb begin
    alu_a  = '0;
    alu_b  = '0;
    alu_op = ALU_ADD;
    case (state)
      S_RANGE: begin
        alu_a  = TOT_W'(dmax);
        alu_b  = TOT_W'(dmin);
        alu_op = ALU_SUB;
      end
      S_DIV: begin
        alu_a  = TOT_W'(trial);
        alu_b  = TOT_W'(divisor);
        alu_op = ALU_SUB;
      end
      S_ERR: begin
        alu_a  = TOT_W'(target);
        alu_b  = TOT_W'(sample_r);
        alu_op = ALU_SUB;
      end
      S_SUM: begin
        alu_a  = TOT_W'(error_sum);
        alu_b  = TOT_W'(err);
        alu_op = ALU_ADD;
      end
      S_DIFF: begin
        alu_a  = TOT_W'(err);
        alu_b  = TOT_W'(last_error);
        alu_op = ALU_SUB;
      end
      S_MUL_P, S_MUL_I, S_MUL_D: begin
        // The top multiplier bit carries negative weight in two's complement.
        alu_a  = acc;
        alu_b  = mplier[0] ? mcand : '0;
        alu_op = mul_last ? ALU_SUB : ALU_ADD;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      error_sum   <= '0;
      last_error  <= '0;
      bound_stale <= 1'b1;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            sample_r <= sample;
            clear_r  <= clear;
            if (clear) begin
              error_sum  <= '0;
              last_error <= '0;
              state      <= S_DONE;
            end else if (bound_stale && (integ != '0)) begin
              state <= S_RANGE;
            end else begin
              state <= S_ERR;
            end
          end
        end
        S_RANGE: begin
          quo   <= num_init;
          rem   <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          // Restoring division; the quotient shifts in where the numerator leaves.
          rem <= div_ge ? alu_res[REM_W-1:0] : trial[REM_W-1:0];
          quo <= {quo[NUM_W-2:0], div_ge};
          cnt <= cnt + 1'b1;
          if (cnt == DIV_LAST) begin
            bound_stale <= 1'b0;
            state       <= S_ERR;
          end
        end
        S_ERR: begin
          err   <= alu_res[ERR_W-1:0];
          state <= S_SUM;
        end
        S_SUM: begin
          sum_r <= sum_sat;
          state <= S_BND;
        end
        S_BND: begin
          if ((integ != '0) && (sum_x > bnd_x)) begin
            error_sum <= bnd_x[AW-1:0];
          end else if ((integ != '0) && (sum_x < neg_bnd)) begin
            error_sum <= neg_bnd[AW-1:0];
          end else begin
            error_sum <= sum_r;
          end
          state <= S_DIFF;
        end
        S_DIFF: begin
          diff       <= alu_res[DIFF_W-1:0];
          last_error <= err;
          acc        <= '0;
          mcand      <= TOT_W'(err);
          mplier     <= prop;
          cnt        <= '0;
          state      <= S_MUL_P;
        end
        S_MUL_P, S_MUL_I, S_MUL_D: begin
          acc    <= alu_res;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt + 1'b1;
          if (mul_last) begin
            cnt <= '0;
            case (state)
              S_MUL_P: begin
                mcand  <= TOT_W'(error_sum);
                mplier <= integ;
                state  <= S_MUL_I;
              end
              S_MUL_I: begin
                mcand  <= TOT_W'(diff);
                mplier <= deriv;
                state  <= S_MUL_D;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (clear_r) begin
              drive   <= '0;
              clamped <= 1'b0;
            end else if (drv_full > max_x) begin
              drive   <= dmax;
              clamped <= 1'b1;
            end else if (drv_full < min_x) begin
              drive   <= dmin;
              clamped <= 1'b1;
            end else begin
              drive   <= drv_full[DW-1:0];
              clamped <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // A new integral gain or new limits make the stored sum bound out of date.
      if (cfg_we && ((cfg_index == REG_INTEG) || (cfg_index == REG_MIN) ||
                     (cfg_index == REG_MAX))) begin
        bound_stale <= 1'b1;
      end
    end
  end

  // A limited drive sits exactly on one of the limits.
  a_clamp_on_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clamped) |-> ((drive == dmax) || (drive == dmin)))
    else $error("clamped drive is not on a limit");

  // Once the sum has been bounded, it lies inside the current bound.
  a_sum_in_bound: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DIFF) && (integ != '0)) |->
      ((err_sum_x <= bnd_x) && (err_sum_x >= neg_bnd)))
    else $error("integral sum outside its bound");

  // The sequencer leaves idle on every accepted transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sequencer still idle after accepting a transaction");

  // The bound is always fresh when the sum is clamped against it.
  a_bound_fresh: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SUM) && (integ != '0)) |-> !bound_stale)
    else $error("sum bound used while out of date");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pid_aw_pkg::*;

  localparam int DW = 16;
  localparam int FRAC = 8;
  localparam longint ACC_HI = 64'sd2147483647;
  localparam longint ACC_LO = -64'sd2147483648;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 100;

  typedef struct packed {
    logic signed [DW-1:0] drive;
    logic                 clamped;
  } drive_res_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_PROP;
  logic [DW-1:0]        cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [DW-1:0] sample = '0;
  logic                 clear = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [DW-1:0] drive;
  logic                 clamped;

  // Shadow copy of the controller registers and its history.
  logic signed [DW-1:0] cfg_kp = 16'sd256;
  logic signed [DW-1:0] cfg_ki = '0;
  logic signed [DW-1:0] cfg_kd = '0;
  logic signed [DW-1:0] cfg_target = '0;
  logic signed [DW-1:0] cfg_min = -16'sd32768;
  logic signed [DW-1:0] cfg_max = 16'sd32767;
  longint               prev_err = 0;
  longint               integ_sum = 0;

  drive_res_t pending_drives[$];
  int         errors = 0;
  int         quiet_cycles = 0;
  bit         no_gaps = 1'b0;
  bit         hold_output = 1'b0;

  pid_controller_antiwindup dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .clear     (clear),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive),
    .clamped   (clamped)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic drive_res_t pid_predict(input logic signed [DW-1:0] smp,
                                             input logic clr);
    drive_res_t res;
    longint     err, acc, span, ki_mag, bound, total, drv;
    res.drive = '0;
    res.clamped = 1'b0;
    if (clr) begin
      prev_err = 0;
      integ_sum = 0;
      return res;
    end
    err = longint'(cfg_target) - longint'(smp);
    acc = integ_sum + err;
    if (acc > ACC_HI) acc = ACC_HI;
    if (acc < ACC_LO) acc = ACC_LO;
    // The anti-windup bound only exists for a non-zero integral gain.
    if (cfg_ki != 0) begin
      span = longint'(cfg_max) - longint'(cfg_min);
      if (span < 0) span = -span;
      ki_mag = longint'(cfg_ki);
      if (ki_mag < 0) ki_mag = -ki_mag;
      bound = (span << FRAC) / (2 * ki_mag);
      if (acc > bound) acc = bound;
      else if (acc < -bound) acc = -bound;
    end
    integ_sum = acc;
    total = longint'(cfg_kp) * err + longint'(cfg_ki) * acc
          + longint'(cfg_kd) * (err - prev_err);
    drv = total >>> FRAC;
    // The upper limit is tested first, which matters when the limits cross.
    if (drv > longint'(cfg_max)) begin
      drv = longint'(cfg_max);
      res.clamped = 1'b1;
    end else if (drv < longint'(cfg_min)) begin
      drv = longint'(cfg_min);
      res.clamped = 1'b1;
    end
    prev_err = err;
    res.drive = drv[DW-1:0];
    return res;
  endfunction

  function automatic logic signed [DW-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return -16'sd32768;
      2: return 16'sd32767;
      3: return DW'($urandom);
      default: return DW'($urandom_range(0, 1536) - 768);
    endcase
  endfunction

  function automatic logic signed [DW-1:0] pick_sample();
    if ($urandom_range(0, 1) == 0) return DW'($urandom);
    return DW'(cfg_target + ($urandom_range(0, 512) - 256));
  endfunction

  task automatic send_sample(input logic signed [DW-1:0] smp, input logic clr);
    if (!no_gaps && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= smp;
    clear <= clr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_drives.push_back(pid_predict(smp, clr));
  endtask

  // Let every outstanding transaction complete so the registers may change.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic signed [DW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PROP:   cfg_kp = val;
      REG_INTEG:  cfg_ki = val;
      REG_DERIV:  cfg_kd = val;
      REG_TARGET: cfg_target = val;
      REG_MIN:    cfg_min = val;
      REG_MAX:    cfg_max = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic signed [DW-1:0] kp, ki, kd, tgt, lo, hi);
    wait_idle();
    write_reg(REG_PROP, kp);
    write_reg(REG_INTEG, ki);
    write_reg(REG_DERIV, kd);
    write_reg(REG_TARGET, tgt);
    write_reg(REG_MIN, lo);
    write_reg(REG_MAX, hi);
  endtask

  task automatic test_reset_defaults();
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(DW'($urandom), 1'b1);
    send_sample(-16'sd1, 1'b0);
  endtask

  task automatic test_gain_extremes();
    set_config(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
               -16'sd32768, 16'sd32767);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b0);
    set_config(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
               -16'sd32768, 16'sd32767);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd0, 1'b0);
  endtask

  // Limits set the wrong way round are accepted as they are.
  task automatic test_crossed_limits();
    set_config(16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd1000, -16'sd1000);
    send_sample(-16'sd5000, 1'b0);
    send_sample(16'sd5000, 1'b0);
    send_sample(16'sd0, 1'b0);
    set_config(16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd7, 16'sd7);
    send_sample(16'sd300, 1'b0);
  endtask

  task automatic test_integral_bound();
    set_config(16'sd0, 16'sd256, 16'sd0, 16'sd0, -16'sd1, 16'sd1);
    send_sample(-16'sd100, 1'b0);
    send_sample(-16'sd100, 1'b0);
    send_sample(16'sd100, 1'b0);
    // With no integral gain the sum runs free and the drive ignores it.
    set_config(16'sd64, 16'sd0, 16'sd128, 16'sd0, -16'sd32768, 16'sd32767);
    send_sample(-16'sd32768, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd12, 1'b1);
  endtask

  // The output is held off while new transactions keep being offered.
  task automatic test_output_backpressure();
    set_config(16'sd200, 16'sd3, -16'sd40, 16'sd1500, -16'sd20000, 16'sd20000);
    hold_output = 1'b1;
    repeat (12) send_sample(pick_sample(), 1'b0);
  endtask

  task automatic test_random_phases();
    logic signed [DW-1:0] lo, hi, tmp;
    for (int phase = 0; phase < 8; phase++) begin
      lo = ($urandom_range(0, 4) == 0) ? -16'sd32768 : DW'($urandom);
      hi = ($urandom_range(0, 4) == 0) ? 16'sd32767 : DW'($urandom);
      if (lo > hi && $urandom_range(0, 9) != 0) begin
        tmp = lo;
        lo = hi;
        hi = tmp;
      end
      set_config(pick_gain(), pick_gain(), pick_gain(),
                 DW'(($urandom_range(0, 1) == 0) ? $urandom
                                                 : $urandom_range(0, 4000) - 2000),
                 lo, hi);
      no_gaps = (phase == 1);
      repeat (52) send_sample(pick_sample(), $urandom_range(0, 99) < 4);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_gain_extremes();
    test_crossed_limits();
    test_integral_bound();
    test_output_backpressure();
    test_random_phases();
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_output) begin
        hold_output = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= no_gaps || ($urandom_range(0, 99) >= 19);
    end
  end

  always @(posedge clk) begin
    drive_res_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (pending_drives.size() == 0) begin
        $error("result transaction with none expected: drive %0d clamped %0b",
               drive, clamped);
        errors++;
      end else begin
        exp_res = pending_drives.pop_front();
        if (drive !== exp_res.drive) begin
          $error("drive: expected %0d, got %0d", exp_res.drive, drive);
          errors++;
        end
        if (clamped !== exp_res.clamped) begin
          $error("clamped: expected %0b, got %0b", exp_res.clamped, clamped);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

endmodule
